### rtl/dst_pkg.sv
// ----------------------------------------------------------------------------
// dst_pkg
// Types, character codes and helper functions for the DATA statement
// tokenizer.
// ----------------------------------------------------------------------------
package dst_pkg;

    localparam int unsigned LEN_W = 12;

    localparam logic [LEN_W-1:0] BARE_MAX   = 12'd255;
    localparam logic [LEN_W-1:0] STRING_MAX = 12'd4095;

    localparam logic [7:0] CH_COLON     = 8'h3A;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_COMMA     = 8'h2C;
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_CR        = 8'h0D;

    localparam logic [2:0] KW_LEN = 3'd4;
    localparam logic [7:0] KW_TEXT [4] = '{8'h44, 8'h41, 8'h54, 8'h41};

    typedef enum logic [7:0] {
        PH_LEAD   = 8'b0000_0001,
        PH_KEY    = 8'b0000_0010,
        PH_WAIT   = 8'b0000_0100,
        PH_BARE   = 8'b0000_1000,
        PH_STR    = 8'b0001_0000,
        PH_STRQ   = 8'b0010_0000,
        PH_AFTER  = 8'b0100_0000,
        PH_IGNORE = 8'b1000_0000
    } t_phase;

    typedef struct packed {
        logic       vld;
        logic [7:0] sp;
        logic       has;
        logic [7:0] ch;
    } t_piece;

    typedef struct packed {
        logic [7:0]  sp;
        logic        has;
        logic [7:0]  ch;
        logic        last;
        logic [15:0] line;
    } t_result;

    localparam t_piece PIECE_NONE  = '{vld: 1'b0, sp: 8'd0, has: 1'b0, ch: 8'd0};
    localparam t_piece PIECE_EMPTY = '{vld: 1'b1, sp: 8'd0, has: 1'b0, ch: 8'd0};

    function automatic logic f_is_ws(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic logic f_is_alpha(input logic [7:0] c);
        return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
    endfunction

    function automatic logic [7:0] f_to_upper(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) ? (c - 8'd32) : c;
    endfunction

    // An item is open while a bare or quoted value is being collected
    function automatic logic f_open(input t_phase ph);
        return (ph == PH_BARE) || (ph == PH_STR) || (ph == PH_STRQ);
    endfunction

    function automatic t_piece f_mk(input logic [7:0] sp, input logic has,
                                    input logic [7:0] ch);
        return '{vld: 1'b1, sp: sp, has: has, ch: ch};
    endfunction

endpackage

### rtl/dst_in_if.sv
// ----------------------------------------------------------------------------
// dst_in_if
// Character channel: one byte of program text with its line number and
// end-of-line mark.
// ----------------------------------------------------------------------------
interface dst_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  text_char;
    logic [15:0] line_number;
    logic        end_of_line;

    modport source (output valid, text_char, line_number, end_of_line, input ready);
    modport sink   (input valid, text_char, line_number, end_of_line, output ready);
endinterface

### rtl/dst_out_if.sv
// ----------------------------------------------------------------------------
// dst_out_if
// Item piece channel: a run of spaces, an optional character and the
// last-piece mark of one DATA item.
// ----------------------------------------------------------------------------
interface dst_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  spaces_before;
    logic        has_char;
    logic [7:0]  item_char;
    logic        last_of_item;
    logic [15:0] item_line;

    modport source (output valid, spaces_before, has_char, item_char, last_of_item,
                    item_line, input ready);
    modport sink   (input valid, spaces_before, has_char, item_char, last_of_item,
                    item_line, output ready);
endinterface

### rtl/data_statement_tokenizer.sv
// ----------------------------------------------------------------------------
// data_statement_tokenizer
// Splits program text into DATA statement items, one character per cycle while not stalled.
// ----------------------------------------------------------------------------
// The block takes one character per clock cycle while the result queue has
// room. A character is registered, decoded against the parse state and its
// pieces written into a two-entry result queue once the queue has room for
// them; the queue drains one piece per cycle while the receiver is ready.
// Most characters give zero or one piece; a character that closes an item on
// the last byte of a line gives two, so the sustained rate is one character
// per cycle as long as the receiver is ready and a character that gives no
// piece comes between two such pairs. Each item's pieces are held back by
// one so that the final piece can carry the last-of-item mark.
module data_statement_tokenizer (
    input  logic      i_clk,
    input  logic      i_rst_n,
    dst_in_if.sink    i_text,
    dst_out_if.source o_tok
);
    import dst_pkg::*;

    // input register
    logic        r_in_vld;
    logic [7:0]  r_in_char;
    logic [15:0] r_in_line;
    logic        r_in_eol;

    // parse state
    logic             r_par,  n_par;
    t_phase           r_ph,   n_ph;
    logic [2:0]       r_kw,   n_kw;
    logic [7:0]       r_pend, n_pend;
    t_piece           r_held, n_held;
    logic [LEN_W-1:0] r_len,  n_len;

    // result queue
    t_result r_q0, r_q1;
    logic [1:0] r_cnt, n_cnt;

    logic       a_vld, a_last, b_vld;
    t_piece     a_piece, b_piece, p_piece;
    logic       p_do, fin_do, wait_do, bare_do, str_do, after_do;
    logic       c_ws, c_sep;
    logic [7:0] c_up;
    logic [LEN_W-1:0] avail;
    t_result    res0, res1;
    logic [1:0] n_res, cnt_ap, free;
    logic       pop, commit;

    assign c_ws  = f_is_ws(r_in_char);
    assign c_up  = f_to_upper(r_in_char);
    assign c_sep = !r_par && ((r_in_char == CH_COLON) || (r_in_char == CH_BACKSLASH));
    assign avail = BARE_MAX - r_len;

    always_comb begin
        n_par    = r_par;
        n_ph     = r_ph;
        n_kw     = r_kw;
        n_pend   = r_pend;
        n_held   = r_held;
        n_len    = r_len;
        a_vld    = 1'b0;
        a_last   = 1'b0;
        a_piece  = PIECE_NONE;
        b_vld    = 1'b0;
        b_piece  = PIECE_NONE;
        p_do     = 1'b0;
        p_piece  = PIECE_NONE;
        fin_do   = 1'b0;
        wait_do  = 1'b0;
        bare_do  = 1'b0;
        str_do   = 1'b0;
        after_do = 1'b0;

        if (c_sep) begin
            if (f_open(r_ph)) begin
                a_vld   = 1'b1;
                a_last  = 1'b1;
                a_piece = r_held.vld ? r_held : PIECE_EMPTY;
            end
            n_par  = 1'b0;
            n_ph   = PH_LEAD;
            n_kw   = 3'd0;
            n_pend = 8'd0;
            n_held = PIECE_NONE;
            n_len  = '0;
        end else begin
            if (r_in_char == CH_QUOTE) begin
                n_par = !r_par;
            end
            case (r_ph)
                PH_LEAD: begin
                    if (!c_ws) begin
                        if (c_up == KW_TEXT[0]) begin
                            n_ph = PH_KEY;
                            n_kw = 3'd1;
                        end else begin
                            n_ph = PH_IGNORE;
                        end
                    end
                end
                PH_KEY: begin
                    if (f_is_alpha(r_in_char)) begin
                        if ((r_kw < KW_LEN) && (c_up == KW_TEXT[r_kw[1:0]])) begin
                            n_kw = r_kw + 3'd1;
                        end else begin
                            n_ph = PH_IGNORE;
                        end
                    end else if (r_kw == KW_LEN) begin
                        n_ph    = PH_WAIT;
                        wait_do = 1'b1;
                    end else begin
                        n_ph = PH_IGNORE;
                    end
                end
                PH_WAIT: wait_do = 1'b1;
                PH_BARE: begin
                    if (r_in_char == CH_COMMA) begin
                        fin_do = 1'b1;
                        n_ph   = PH_WAIT;
                    end else if (c_ws) begin
                        if (r_pend != 8'hFF) begin
                            n_pend = r_pend + 8'd1;
                        end
                    end else begin
                        bare_do = 1'b1;
                    end
                end
                PH_STR: begin
                    if (r_in_char == CH_QUOTE) begin
                        n_ph = PH_STRQ;
                    end else begin
                        str_do = 1'b1;
                    end
                end
                PH_STRQ: begin
                    if (r_in_char == CH_QUOTE) begin
                        n_ph   = PH_STR;
                        str_do = 1'b1;
                    end else begin
                        fin_do   = 1'b1;
                        after_do = 1'b1;
                    end
                end
                PH_AFTER: after_do = 1'b1;
                default: ;
            endcase

            // first character of a new item: no held piece to flush
            if (wait_do && !c_ws && (r_in_char != CH_COMMA)) begin
                n_pend = 8'd0;
                n_held = PIECE_NONE;
                n_len  = '0;
                if (r_in_char == CH_QUOTE) begin
                    n_ph = PH_STR;
                end else begin
                    n_ph   = PH_BARE;
                    n_held = f_mk(8'd0, 1'b1, r_in_char);
                    n_len  = {{(LEN_W-1){1'b0}}, 1'b1};
                end
            end

            // cut the bare item once it reaches its length limit
            if (bare_do && (r_len < BARE_MAX)) begin
                p_do   = 1'b1;
                n_pend = 8'd0;
                if ({{(LEN_W-8){1'b0}}, r_pend} >= avail) begin
                    p_piece = f_mk(avail[7:0], 1'b0, 8'd0);
                    n_len   = BARE_MAX;
                end else begin
                    p_piece = f_mk(r_pend, 1'b1, r_in_char);
                    n_len   = r_len + {{(LEN_W-8){1'b0}}, r_pend} + {{(LEN_W-1){1'b0}}, 1'b1};
                end
            end

            if (str_do && (r_len < STRING_MAX)) begin
                p_do    = 1'b1;
                n_len   = r_len + {{(LEN_W-1){1'b0}}, 1'b1};
                p_piece = f_mk(8'd0, 1'b1, r_in_char);
            end

            if (p_do) begin
                if (r_held.vld) begin
                    a_vld   = 1'b1;
                    a_piece = r_held;
                end
                n_held = p_piece;
            end

            if (fin_do) begin
                a_vld   = 1'b1;
                a_last  = 1'b1;
                a_piece = r_held.vld ? r_held : PIECE_EMPTY;
                n_held  = PIECE_NONE;
                n_pend  = 8'd0;
                n_len   = '0;
            end

            // after a closing quote only a comma continues the list
            if (after_do) begin
                n_ph = PH_AFTER;
                if (!c_ws) begin
                    n_ph = (r_in_char == CH_COMMA) ? PH_WAIT : PH_IGNORE;
                end
            end
        end

        if (r_in_eol) begin
            if (f_open(n_ph)) begin
                b_vld   = 1'b1;
                b_piece = n_held.vld ? n_held : PIECE_EMPTY;
            end
            n_par  = 1'b0;
            n_ph   = PH_LEAD;
            n_kw   = 3'd0;
            n_pend = 8'd0;
            n_held = PIECE_NONE;
            n_len  = '0;
        end
    end

    // pack the pieces in order: the step's own piece first, the line end second
    always_comb begin
        res0 = '{sp: b_piece.sp, has: b_piece.has, ch: b_piece.ch, last: 1'b1,
                 line: r_in_line};
        res1 = res0;
        if (a_vld) begin
            res0 = '{sp: a_piece.sp, has: a_piece.has, ch: a_piece.ch, last: a_last,
                     line: r_in_line};
        end
        n_res = {1'b0, a_vld} + {1'b0, b_vld};
    end

    assign pop    = o_tok.valid && o_tok.ready;
    assign cnt_ap = r_cnt - {1'b0, pop};
    assign free   = 2'd2 - cnt_ap;
    assign commit = r_in_vld && (n_res <= free);
    assign n_cnt  = cnt_ap + (commit ? n_res : 2'd0);

    assign i_text.ready = !r_in_vld || commit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
            r_par    <= 1'b0;
            r_ph     <= PH_LEAD;
            r_kw     <= 3'd0;
            r_pend   <= 8'd0;
            r_held   <= PIECE_NONE;
            r_len    <= '0;
            r_cnt    <= 2'd0;
        end else begin
            if (i_text.ready) begin
                r_in_vld <= i_text.valid;
            end
            if (commit) begin
                r_par  <= n_par;
                r_ph   <= n_ph;
                r_kw   <= n_kw;
                r_pend <= n_pend;
                r_held <= n_held;
                r_len  <= n_len;
            end
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_text.valid && i_text.ready) begin
            r_in_char <= i_text.text_char;
            r_in_line <= i_text.line_number;
            r_in_eol  <= i_text.end_of_line;
        end
        // write the new pieces behind what remains, else advance the queue
        if (commit && (n_res != 2'd0) && (cnt_ap == 2'd0)) begin
            r_q0 <= res0;
        end else if (pop) begin
            r_q0 <= r_q1;
        end
        if (commit && (n_res != 2'd0)) begin
            if (cnt_ap == 2'd0) begin
                if (n_res == 2'd2) begin
                    r_q1 <= res1;
                end
            end else begin
                r_q1 <= res0;
            end
        end
    end

    assign o_tok.valid         = (r_cnt != 2'd0);
    assign o_tok.spaces_before = r_q0.sp;
    assign o_tok.has_char      = r_q0.has;
    assign o_tok.item_char     = r_q0.ch;
    assign o_tok.last_of_item  = r_q0.last;
    assign o_tok.item_line     = r_q0.line;

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("result queue count out of range");

    a_held_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held.vld |-> f_open(r_ph))
        else $error("held piece outside an open item");

    a_kw_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_kw <= KW_LEN)
        else $error("keyword letter count out of range");

    a_bare_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ph == PH_BARE) |-> (r_len <= BARE_MAX))
        else $error("bare item longer than its limit");

endmodule

### tb/data_statement_tokenizer_tb.sv
// ----------------------------------------------------------------------------
// data_statement_tokenizer_tb
// Drives program lines into the DATA statement tokenizer one character per
// transfer and checks every item piece against a cycle-free model of the
// parser. The lines are mostly DATA statements with random items, plus noise,
// broken keywords, long items and one oversized string.
// ----------------------------------------------------------------------------
module data_statement_tokenizer_tb;
    import dst_pkg::*;

    localparam int RANDOM_CHARS   = 1700;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 10;

    // Parser model plus the queue of pieces it has predicted
    class piece_scoreboard;
        t_result     expected_pieces[$];
        int unsigned errors;
        bit          in_quote;
        t_phase      phase;
        logic [2:0]  kw_cnt;
        logic [7:0]  pend_sp;
        t_piece      held;
        int unsigned item_len;

        function new();
            errors = 0;
            clear_segment();
        endfunction

        function int pending();
            return expected_pieces.size();
        endfunction

        function bit is_blank(logic [7:0] c);
            return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
        endfunction

        function bit is_letter(logic [7:0] c);
            return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
        endfunction

        function logic [7:0] upcase(logic [7:0] c);
            return (c >= "a" && c <= "z") ? c - 8'd32 : c;
        endfunction

        function void clear_segment();
            in_quote = 1'b0;
            phase    = PH_LEAD;
            kw_cnt   = '0;
            pend_sp  = '0;
            held     = PIECE_NONE;
            item_len = 0;
        endfunction

        function void put_piece(t_piece p, bit last, logic [15:0] line);
            t_result r;
            r.sp   = p.sp;
            r.has  = p.has;
            r.ch   = p.ch;
            r.last = last;
            r.line = line;
            expected_pieces.push_back(r);
        endfunction

        // Hold back one piece so the final one can carry the last mark
        function void hold_piece(t_piece p, logic [15:0] line);
            if (held.vld)
                put_piece(held, 1'b0, line);
            held = p;
        endfunction

        function void close_item(logic [15:0] line);
            if (phase == PH_BARE || phase == PH_STR || phase == PH_STRQ)
                put_piece(held.vld ? held : PIECE_EMPTY, 1'b1, line);
            held     = PIECE_NONE;
            pend_sp  = '0;
            item_len = 0;
        endfunction

        function void add_bare(logic [7:0] c, logic [15:0] line);
            int unsigned avail;
            t_piece      p;
            if (item_len >= BARE_MAX)
                return;
            avail = BARE_MAX - item_len;
            // Cut inside a space run: keep only the spaces that fit
            if (pend_sp >= avail) begin
                p        = '{vld: 1'b1, sp: 8'(avail), has: 1'b0, ch: 8'h00};
                item_len = BARE_MAX;
            end else begin
                p        = '{vld: 1'b1, sp: pend_sp, has: 1'b1, ch: c};
                item_len = item_len + pend_sp + 1;
            end
            pend_sp = '0;
            hold_piece(p, line);
        endfunction

        function void add_str(logic [7:0] c, logic [15:0] line);
            if (item_len >= STRING_MAX)
                return;
            item_len++;
            hold_piece('{vld: 1'b1, sp: 8'd0, has: 1'b1, ch: c}, line);
        endfunction

        function void start_value(logic [7:0] c, logic [15:0] line);
            if (is_blank(c) || c == CH_COMMA)
                return;
            held     = PIECE_NONE;
            item_len = 0;
            pend_sp  = '0;
            if (c == CH_QUOTE) begin
                phase = PH_STR;
            end else begin
                phase = PH_BARE;
                add_bare(c, line);
            end
        endfunction

        function void after_value(logic [7:0] c);
            if (is_blank(c))
                return;
            phase = (c == CH_COMMA) ? PH_WAIT : PH_IGNORE;
        endfunction

        function void parse_char(logic [7:0] c, logic [15:0] line);
            case (phase)
                PH_LEAD: begin
                    if (!is_blank(c)) begin
                        if (upcase(c) == KW_TEXT[0]) begin
                            phase  = PH_KEY;
                            kw_cnt = 3'd1;
                        end else begin
                            phase = PH_IGNORE;
                        end
                    end
                end
                PH_KEY: begin
                    if (is_letter(c)) begin
                        if (kw_cnt < KW_LEN && upcase(c) == KW_TEXT[kw_cnt[1:0]])
                            kw_cnt++;
                        else
                            phase = PH_IGNORE;
                    end else if (kw_cnt == KW_LEN) begin
                        phase = PH_WAIT;
                        start_value(c, line);
                    end else begin
                        phase = PH_IGNORE;
                    end
                end
                PH_WAIT: start_value(c, line);
                PH_BARE: begin
                    if (c == CH_COMMA) begin
                        close_item(line);
                        phase = PH_WAIT;
                    end else if (is_blank(c)) begin
                        if (pend_sp != 8'hFF)
                            pend_sp++;
                    end else begin
                        add_bare(c, line);
                    end
                end
                PH_STR: begin
                    if (c == CH_QUOTE)
                        phase = PH_STRQ;
                    else
                        add_str(c, line);
                end
                PH_STRQ: begin
                    // A doubled quote stands for one quote character
                    if (c == CH_QUOTE) begin
                        phase = PH_STR;
                        add_str(c, line);
                    end else begin
                        close_item(line);
                        phase = PH_AFTER;
                        after_value(c);
                    end
                end
                PH_AFTER: after_value(c);
                default: ;
            endcase
        endfunction

        function void note_char(logic [7:0] c, logic [15:0] line, logic eol);
            if (!in_quote && (c == CH_COLON || c == CH_BACKSLASH)) begin
                close_item(line);
                clear_segment();
            end else begin
                if (c == CH_QUOTE)
                    in_quote = !in_quote;
                parse_char(c, line);
            end
            if (eol) begin
                close_item(line);
                clear_segment();
            end
        endfunction

        function string piece_text(t_result r);
            return $sformatf("sp=%0d has=%0b ch=%02h last=%0b line=%0d",
                             r.sp, r.has, r.ch, r.last, r.line);
        endfunction

        function void check_piece(t_result got);
            t_result want;
            if (expected_pieces.size() == 0) begin
                $display("%0t unexpected piece: %s", $time, piece_text(got));
                errors++;
                return;
            end
            want = expected_pieces.pop_front();
            if (got !== want) begin
                $display("%0t piece mismatch: expected %s", $time, piece_text(want));
                $display("%0t                 actual   %s", $time, piece_text(got));
                errors++;
            end
        endfunction
    endclass

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    dst_in_if  text_if();
    dst_out_if tok_if();

    data_statement_tokenizer i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_text  (text_if),
        .o_tok   (tok_if)
    );

    piece_scoreboard sb = new();

    logic [7:0]  line_buf[$];
    int unsigned burst_left;
    bit          no_gaps;
    int unsigned chars_sent;
    logic [7:0]  stall_pat;
    int unsigned pat_age;
    int unsigned idle_cycles;

    always #10 i_clk = ~i_clk;

    // Receiver: stall on a rotating pattern that is reloaded now and then
    initial begin
        tok_if.ready = 1'b0;
        stall_pat    = 8'hFF;
        pat_age      = 0;
    end

    always @(negedge i_clk) begin
        if (pat_age == 0) begin
            case ($urandom_range(0, 3))
                0: stall_pat = 8'hFF;
                1: stall_pat = 8'($urandom);
                default: stall_pat = 8'($urandom | $urandom);
            endcase
            pat_age = $urandom_range(16, 128);
        end
        pat_age--;
        tok_if.ready = stall_pat[0];
        stall_pat    = {stall_pat[0], stall_pat[7:1]};
    end

    // Sample both channels at the rising edge; the watchdog counts dead cycles
    always @(posedge i_clk) begin
        t_result got;
        bit      moved;
        moved = 1'b0;
        if (i_rst_n && text_if.valid === 1'b1 && text_if.ready === 1'b1) begin
            sb.note_char(text_if.text_char, text_if.line_number, text_if.end_of_line);
            moved = 1'b1;
        end
        if (i_rst_n && tok_if.valid === 1'b1 && tok_if.ready === 1'b1) begin
            got.sp   = tok_if.spaces_before;
            got.has  = tok_if.has_char;
            got.ch   = tok_if.item_char;
            got.last = tok_if.last_of_item;
            got.line = tok_if.item_line;
            sb.check_piece(got);
            moved = 1'b1;
        end
        idle_cycles = moved ? 0 : idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t watchdog: no transfer for %0d cycles", $time, idle_cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic send_char(input logic [7:0] c, input logic [15:0] line, input logic eol);
        int unsigned gap;
        if (burst_left == 0) begin
            gap        = no_gaps ? 0 : $urandom_range(1, ($urandom_range(0, 3) == 0) ? 20 : 4);
            burst_left = $urandom_range(1, 40);
            if (gap != 0) begin
                @(negedge i_clk);
                text_if.valid     = 1'b0;
                text_if.text_char = 8'($urandom);
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        burst_left--;
        @(negedge i_clk);
        text_if.valid       = 1'b1;
        text_if.text_char   = c;
        text_if.line_number = line;
        text_if.end_of_line = eol;
        @(posedge i_clk);
        while (text_if.ready !== 1'b1)
            @(posedge i_clk);
    endtask

    task automatic send_line(input logic [15:0] line);
        no_gaps = ($urandom_range(0, 3) == 0);
        if (line_buf.size() == 0)
            line_buf.push_back("x");
        foreach (line_buf[i])
            send_char(line_buf[i], line, i == line_buf.size() - 1);
        chars_sent += line_buf.size();
        line_buf.delete();
    endtask

    function automatic void push_text(string s);
        for (int i = 0; i < s.len(); i++)
            line_buf.push_back(s[i]);
    endfunction

    function automatic logic [7:0] blank_char();
        return ($urandom_range(0, 3) == 0) ? 8'($urandom_range(9, 13)) : CH_SPACE;
    endfunction

    function automatic void add_blanks(int unsigned lo, int unsigned hi);
        repeat ($urandom_range(lo, hi)) line_buf.push_back(blank_char());
    endfunction

    // Any byte that cannot end, split or quote a bare item
    function automatic logic [7:0] bare_char();
        logic [7:0] c;
        do begin
            c = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(33, 126)) : 8'($urandom);
        end while (c == CH_COMMA || c == CH_COLON || c == CH_BACKSLASH ||
                   c == CH_QUOTE || sb.is_blank(c));
        return c;
    endfunction

    function automatic void add_keyword();
        int unsigned n;
        if ($urandom_range(0, 19) != 0) begin
            foreach (KW_TEXT[i])
                line_buf.push_back(KW_TEXT[i] | ($urandom_range(0, 1) ? 8'h20 : 8'h00));
        end else begin
            // Broken keyword: truncated, misspelled or overlong
            n = $urandom_range(0, 5);
            for (int i = 0; i < n; i++)
                line_buf.push_back(($urandom_range(0, 2) != 0) ? KW_TEXT[i % 4]
                                                                : 8'($urandom_range(65, 90)));
        end
    endfunction

    function automatic void add_bare_item();
        if ($urandom_range(0, 59) == 0) begin
            // Long item: cut by length, often inside a long space run
            repeat ($urandom_range(240, 254)) line_buf.push_back(bare_char());
            repeat ($urandom_range(1, 300)) line_buf.push_back(CH_SPACE);
            line_buf.push_back(bare_char());
        end else begin
            add_blanks(0, 2);
            repeat ($urandom_range(0, 6)) begin
                if ($urandom_range(0, 3) == 0)
                    add_blanks(1, 3);
                line_buf.push_back(bare_char());
            end
            add_blanks(0, 2);
        end
    endfunction

    function automatic void add_quoted_item(bit closed);
        logic [7:0] c;
        line_buf.push_back(CH_QUOTE);
        repeat ($urandom_range(0, 8)) begin
            if ($urandom_range(0, 7) == 0) begin
                line_buf.push_back(CH_QUOTE);
                line_buf.push_back(CH_QUOTE);
            end else begin
                do c = 8'($urandom); while (c == CH_QUOTE);
                line_buf.push_back(c);
            end
        end
        if (!closed)
            return;
        line_buf.push_back(CH_QUOTE);
        case ($urandom_range(0, 9))
            0: line_buf.push_back(bare_char());
            1, 2: add_blanks(1, 2);
            default: ;
        endcase
    endfunction

    function automatic void add_segment();
        int unsigned n;
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 12)) line_buf.push_back(8'($urandom));
            return;
        end
        add_blanks(0, 2);
        add_keyword();
        add_blanks(0, 2);
        n = $urandom_range(1, 4);
        for (int i = 0; i < n; i++) begin
            if (i != 0)
                line_buf.push_back(CH_COMMA);
            add_blanks(0, 1);
            case ($urandom_range(0, 9))
                0: add_blanks(0, 2);
                1, 2, 3, 4: add_quoted_item(i != n - 1 || $urandom_range(0, 9) != 0);
                default: add_bare_item();
            endcase
        end
    endfunction

    function automatic void build_line();
        int unsigned n;
        n = $urandom_range(1, 3);
        for (int i = 0; i < n; i++) begin
            if (i != 0)
                line_buf.push_back($urandom_range(0, 1) ? CH_COLON : CH_BACKSLASH);
            add_segment();
        end
        if ($urandom_range(0, 5) == 0)
            line_buf.push_back($urandom_range(0, 1) ? CH_COLON : CH_BACKSLASH);
    endfunction

    function automatic logic [15:0] pick_line();
        case ($urandom_range(0, 9))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        text_if.valid       = 1'b0;
        text_if.text_char   = 8'h00;
        text_if.line_number = 16'h0000;
        text_if.end_of_line = 1'b0;
        burst_left          = 0;
        no_gaps             = 1'b0;
        chars_sent          = 0;
        idle_cycles         = 0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Empty quoted item, comma after a closing quote, top byte, separator on line end
        push_text("data\"\",");
        line_buf.push_back(8'hFF);
        push_text(" b:");
        send_line(16'h0000);
        // Doubled quote, junk after a closing quote, zero byte ignored
        push_text("DaTa\"a\"\"b\" q,");
        line_buf.push_back(8'h00);
        send_line(16'hFFFF);
        // Unclosed quote runs to the end of the line
        push_text("DATA \"z");
        send_line(16'h0001);

        // One string longer than the length limit
        push_text("DATA \"");
        repeat (STRING_MAX + 3) line_buf.push_back(8'($urandom_range(97, 122)));
        line_buf.push_back(CH_QUOTE);
        send_line(pick_line());

        chars_sent = 0;
        while (chars_sent < RANDOM_CHARS) begin
            build_line();
            send_line(pick_line());
        end

        @(negedge i_clk);
        text_if.valid = 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
